### rtl/stereo_mpx_peak_hold_meter_macros.svh
// assertion macros used by the checker file of the peak hold meter
`ifndef STEREO_MPX_PEAK_HOLD_METER_MACROS_SVH
`define STEREO_MPX_PEAK_HOLD_METER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define SMPHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define SMPHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks through reset
`define SMPHM_ASSERT_RST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/smphm_pkg.sv
// shared widths, codes, reset values and lane structs of the peak hold meter
package smphm_pkg;

  localparam int AUDIO_W     = 16;
  localparam int MPX_W       = 24;
  localparam int AGE_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    ZONE_GREEN  = 2'd0,
    ZONE_YELLOW = 2'd1,
    ZONE_RED    = 2'd2
  } zone_t;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_GREEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_YELLOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MPX_GREEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MPX_YELLOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MPX_TOL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd5;

  localparam logic [AUDIO_W-1:0] RST_AUDIO_GREEN  = 16'd8230;
  localparam logic [AUDIO_W-1:0] RST_AUDIO_YELLOW = 16'd11626;
  localparam logic [MPX_W-1:0]   RST_MPX_GREEN    = 24'd2097264;
  localparam logic [MPX_W-1:0]   RST_MPX_YELLOW   = 24'd2621580;
  localparam logic [MPX_W-1:0]   RST_MPX_TOL      = 24'd3495;
  localparam logic [AGE_W-1:0]   RST_HOLD_TICKS   = 16'd500;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // per-beat control broadcast to every lane
  typedef struct packed {
    logic take;
    logic sample;
    logic reload;
  } lane_ctrl_t;

  typedef struct packed {
    zone_t              zone;
    logic [AUDIO_W-1:0] peak;
    logic               rise;
    logic               mark;
  } audio_res_t;

  typedef struct packed {
    zone_t            zone;
    logic [MPX_W-1:0] peak;
    logic             rise;
    logic             mark;
  } mpx_res_t;

endpackage

### rtl/stereo_mpx_peak_hold_meter.sv
// top level of the stereo audio and mpx peak hold level meter
//
// in channel: one beat is either a sample set (in_tuser low) carrying left,
// right and a raw mpx word, or a one millisecond tick (in_tuser high).
// out channel: one result beat per input beat with three zones (green,
// yellow, red), the three held peaks and the three peak-marker flags.
// cfg channel: cfg_index selects a threshold or the hold time, cfg_data is
// written when cfg_valid and cfg_ready meet; unknown indexes are dropped.
// the result beat sits in an output register, and one beat is taken
// every cycle while that register is free or drains; the held peaks and the
// shared hold age close their update loop in the cycle a beat is taken, and
// three lanes run side by side. while the receiver stalls the result beat
// holds, and a new input is taken only in the cycle it drains.
// reset (synchronous, rst_n low) clears the peaks and hold age, loads the
// default thresholds and drops any pending result; both ready outputs stay
// low while reset is held.
module stereo_mpx_peak_hold_meter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] left_sample, [31:16] right_sample, [55:32] mpx_word
  input  logic [smphm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] mode
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [1:0] left_zone, [3:2] right_zone, [5:4] mpx_zone, [21:6] left_peak_out,
  // [37:22] right_peak_out, [61:38] mpx_peak_out, [62] left_mark,
  // [63] right_mark, [64] mpx_mark, rest zero
  output logic [smphm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smphm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smphm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import smphm_pkg::*;

  logic [AUDIO_W-1:0] audio_green_r;
  logic [AUDIO_W-1:0] audio_yellow_r;
  logic [MPX_W-1:0]   mpx_green_r;
  logic [MPX_W-1:0]   mpx_yellow_r;
  logic [MPX_W-1:0]   mpx_tol_r;
  logic [AGE_W-1:0]   hold_ticks_r;

  logic       take;
  logic       reload;
  logic       sample;
  lane_ctrl_t ctrl;
  audio_res_t left_res;
  audio_res_t right_res;
  mpx_res_t   mpx_res;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_green_r  <= RST_AUDIO_GREEN;
      audio_yellow_r <= RST_AUDIO_YELLOW;
      mpx_green_r    <= RST_MPX_GREEN;
      mpx_yellow_r   <= RST_MPX_YELLOW;
      mpx_tol_r      <= RST_MPX_TOL;
      hold_ticks_r   <= RST_HOLD_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AUDIO_GREEN:  audio_green_r  <= cfg_data[AUDIO_W-1:0];
        REG_AUDIO_YELLOW: audio_yellow_r <= cfg_data[AUDIO_W-1:0];
        REG_MPX_GREEN:    mpx_green_r    <= cfg_data[MPX_W-1:0];
        REG_MPX_YELLOW:   mpx_yellow_r   <= cfg_data[MPX_W-1:0];
        REG_MPX_TOL:      mpx_tol_r      <= cfg_data[MPX_W-1:0];
        REG_HOLD_TICKS:   hold_ticks_r   <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample      = (in_tuser == MODE_SAMPLE);
  assign ctrl.take   = take;
  assign ctrl.sample = sample;
  assign ctrl.reload = reload;

  smphm_audio_lane u_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sample     (in_tdata[15:0]),
    .green_thr  (audio_green_r),
    .yellow_thr (audio_yellow_r),
    .res        (left_res)
  );

  smphm_audio_lane u_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .sample     (in_tdata[31:16]),
    .green_thr  (audio_green_r),
    .yellow_thr (audio_yellow_r),
    .res        (right_res)
  );

  smphm_mpx_lane u_mpx (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .mpx_word       (in_tdata[55:32]),
    .green_thr      (mpx_green_r),
    .yellow_thr     (mpx_yellow_r),
    .mark_tolerance (mpx_tol_r),
    .res            (mpx_res)
  );

  smphm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .sample     (sample),
    .hold_ticks (hold_ticks_r),
    .left_res   (left_res),
    .right_res  (right_res),
    .mpx_res    (mpx_res),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .take       (take),
    .reload     (reload),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/smphm_audio_lane.sv
// one audio channel lane: magnitude, zone, held peak and peak marker
module smphm_audio_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  smphm_pkg::lane_ctrl_t          ctrl,
  input  logic [smphm_pkg::AUDIO_W-1:0]  sample,
  input  logic [smphm_pkg::AUDIO_W-1:0]  green_thr,
  input  logic [smphm_pkg::AUDIO_W-1:0]  yellow_thr,
  output smphm_pkg::audio_res_t          res
);
  import smphm_pkg::*;

  logic [AUDIO_W-1:0] peak_r;
  logic [AUDIO_W-1:0] peak_nxt;
  logic [AUDIO_W-1:0] mag;
  logic               above;

  // full-scale negative wraps to 0x8000, which is the right magnitude
  assign mag   = sample[AUDIO_W-1] ? (~sample + 1'b1) : sample;
  assign above = mag > peak_r;

  always_comb begin
    peak_nxt = peak_r;
    if (ctrl.sample && (ctrl.reload || above)) begin
      peak_nxt = mag;
    end
  end

  always_comb begin
    res.peak = peak_nxt;
    res.rise = ctrl.sample && !ctrl.reload && above;
    res.mark = ctrl.sample && (mag == peak_nxt) && (peak_nxt > green_thr);
    if (!ctrl.sample) begin
      res.zone = ZONE_GREEN;
    end else if (mag <= green_thr) begin
      res.zone = ZONE_GREEN;
    end else if (mag <= yellow_thr) begin
      res.zone = ZONE_YELLOW;
    end else begin
      res.zone = ZONE_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (ctrl.take) begin
      peak_r <= peak_nxt;
    end
  end

endmodule

### rtl/smphm_mpx_lane.sv
// mpx lane: magnitude, zone, held peak and tolerance-based peak marker
module smphm_mpx_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smphm_pkg::lane_ctrl_t        ctrl,
  input  logic [smphm_pkg::MPX_W-1:0]  mpx_word,
  input  logic [smphm_pkg::MPX_W-1:0]  green_thr,
  input  logic [smphm_pkg::MPX_W-1:0]  yellow_thr,
  input  logic [smphm_pkg::MPX_W-1:0]  mark_tolerance,
  output smphm_pkg::mpx_res_t          res
);
  import smphm_pkg::*;

  logic [MPX_W-1:0] peak_r;
  logic [MPX_W-1:0] peak_nxt;
  logic [MPX_W-1:0] mag;
  logic [MPX_W-1:0] diff;
  logic             above;

  assign mag   = mpx_word[MPX_W-1] ? (~mpx_word + 1'b1) : mpx_word;
  assign above = mag > peak_r;

  always_comb begin
    peak_nxt = peak_r;
    if (ctrl.sample && (ctrl.reload || above)) begin
      peak_nxt = mag;
    end
  end

  // distance to the updated peak
  assign diff = (mag >= peak_nxt) ? (mag - peak_nxt) : (peak_nxt - mag);

  always_comb begin
    res.peak = peak_nxt;
    res.rise = ctrl.sample && !ctrl.reload && above;
    res.mark = ctrl.sample && (diff <= mark_tolerance) && (mag > green_thr);
    if (!ctrl.sample) begin
      res.zone = ZONE_GREEN;
    end else if (mag <= green_thr) begin
      res.zone = ZONE_GREEN;
    end else if (mag <= yellow_thr) begin
      res.zone = ZONE_YELLOW;
    end else begin
      res.zone = ZONE_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (ctrl.take) begin
      peak_r <= peak_nxt;
    end
  end

endmodule

### rtl/smphm_merge.sv
// merge stage: shared hold age, input handshake and registered result beat
module smphm_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               sample,
  input  logic [smphm_pkg::AGE_W-1:0]        hold_ticks,
  input  smphm_pkg::audio_res_t              left_res,
  input  smphm_pkg::audio_res_t              right_res,
  input  smphm_pkg::mpx_res_t                mpx_res,
  input  logic                               out_tready,
  output logic                               in_tready,
  output logic                               take,
  output logic                               reload,
  output logic                               out_tvalid,
  output logic [smphm_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import smphm_pkg::*;

  logic [AGE_W-1:0]       age_r;
  logic [AGE_W-1:0]       age_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic                   any_rise;

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign take      = in_tvalid && in_tready;
  assign reload    = age_r > hold_ticks;
  assign any_rise  = left_res.rise || right_res.rise || mpx_res.rise;

  always_comb begin
    age_nxt = age_r;
    if (take) begin
      if (sample) begin
        if (reload || any_rise) begin
          age_nxt = '0;
        end
      end else if (age_r != AGE_MAX) begin
        age_nxt = age_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_data_nxt = {
      {(OUT_TDATA_W - 65){1'b0}},
      mpx_res.mark, right_res.mark, left_res.mark,
      mpx_res.peak, right_res.peak, left_res.peak,
      mpx_res.zone, right_res.zone, left_res.zone
    };
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      age_r       <= age_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/smphm_checker.sv
// port-level checker for the peak hold meter, bound to the top level
`include "stereo_mpx_peak_hold_meter_macros.svh"

module smphm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [smphm_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import smphm_pkg::*;

  // reset drops any pending result
  `SMPHM_ASSERT_RST_NXT(a_rst_clears, !rst_n, !out_tvalid, "result valid after reset")

  // every accepted beat shows a result in the next cycle
  `SMPHM_ASSERT_NXT(a_accept_result, in_tvalid && in_tready, out_tvalid, "missing result beat")

  // a stalled result holds
  `SMPHM_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")

  // no zone code beyond red
  `SMPHM_ASSERT_IMP(a_zone_code, out_tvalid,
    out_tdata[1:0] != 2'd3 && out_tdata[3:2] != 2'd3 && out_tdata[5:4] != 2'd3,
    "bad zone code")

  // a left or mpx peak marker needs a level above green
  `SMPHM_ASSERT_IMP(a_mark_zone, out_tvalid && (out_tdata[62] || out_tdata[64]),
    (!out_tdata[62] || out_tdata[1:0] != ZONE_GREEN) &&
    (!out_tdata[64] || out_tdata[5:4] != ZONE_GREEN), "marker in green zone")

endmodule

bind stereo_mpx_peak_hold_meter smphm_checker u_smphm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb_stereo_mpx_peak_hold_meter.sv
// self-checking testbench for the stereo audio and mpx peak hold level meter
`timescale 1ns / 100ps

module tb_stereo_mpx_peak_hold_meter;
  import smphm_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int AUDIO_FULL = 32768;
  localparam int MPX_FULL   = 8388608;

  typedef enum logic [2:0] {
    BEAT_ITEM,
    BEAT_GAP,
    BEAT_CFG,
    BEAT_DRAIN,
    BEAT_CALM
  } feed_kind_t;

  typedef struct {
    feed_kind_t            kind;
    logic                  mode;
    logic [AUDIO_W-1:0]    left_s;
    logic [AUDIO_W-1:0]    right_s;
    logic [MPX_W-1:0]      mpx_s;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    int                    gap_len;
  } feed_t;

  typedef struct packed {
    logic [AUDIO_W-1:0] audio_green;
    logic [AUDIO_W-1:0] audio_yellow;
    logic [MPX_W-1:0]   mpx_green;
    logic [MPX_W-1:0]   mpx_yellow;
    logic [MPX_W-1:0]   mpx_tol;
    logic [AGE_W-1:0]   hold;
  } meter_cfg_t;

  typedef struct packed {
    zone_t              left_zone;
    zone_t              right_zone;
    zone_t              mpx_zone;
    logic [AUDIO_W-1:0] left_peak;
    logic [AUDIO_W-1:0] right_peak;
    logic [MPX_W-1:0]   mpx_peak;
    logic               left_mark;
    logic               right_mark;
    logic               mpx_mark;
  } reading_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [15:0] left_sample, [31:16] right_sample, [55:32] mpx_word
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // [0] mode
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [1:0] left_zone, [3:2] right_zone, [5:4] mpx_zone, [21:6] left_peak_out,
  // [37:22] right_peak_out, [61:38] mpx_peak_out, [62] left_mark,
  // [63] right_mark, [64] mpx_mark, rest zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  stereo_mpx_peak_hold_meter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  feed_t      feed_q[$];
  reading_t   reading_q[$];
  meter_cfg_t live_cfg;
  meter_cfg_t gen_cfg;
  logic [AUDIO_W-1:0] held_left;
  logic [AUDIO_W-1:0] held_right;
  logic [MPX_W-1:0]   held_mpx;
  logic [AGE_W-1:0]   age_count;

  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  logic presenting = 1'b0;
  logic calm = 1'b0;
  logic out_bursty = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   err_count = 0;
  int   readings_seen = 0;
  int   recent_audio = 0;
  int   recent_mpx = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [AUDIO_W-1:0] audio_level(logic [AUDIO_W-1:0] s);
    return s[AUDIO_W-1] ? (~s) + 1'b1 : s;
  endfunction

  function automatic logic [MPX_W-1:0] mpx_level(logic [MPX_W-1:0] s);
    return s[MPX_W-1] ? (~s) + 1'b1 : s;
  endfunction

  function automatic zone_t grade_level(logic [MPX_W-1:0] mag, logic [MPX_W-1:0] green,
                                        logic [MPX_W-1:0] yellow);
    if (mag <= green) return ZONE_GREEN;
    if (mag <= yellow) return ZONE_YELLOW;
    return ZONE_RED;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_AUDIO_GREEN:  live_cfg.audio_green = val[AUDIO_W-1:0];
      REG_AUDIO_YELLOW: live_cfg.audio_yellow = val[AUDIO_W-1:0];
      REG_MPX_GREEN:    live_cfg.mpx_green = val[MPX_W-1:0];
      REG_MPX_YELLOW:   live_cfg.mpx_yellow = val[MPX_W-1:0];
      REG_MPX_TOL:      live_cfg.mpx_tol = val[MPX_W-1:0];
      REG_HOLD_TICKS:   live_cfg.hold = val[AGE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic reading_t predict_reading(logic mode, logic [IN_TDATA_W-1:0] d);
    reading_t           rd;
    logic [AUDIO_W-1:0] lv;
    logic [AUDIO_W-1:0] rv;
    logic [MPX_W-1:0]   mv;
    logic [MPX_W-1:0]   spread;
    rd = '0;
    if (mode == MODE_TICK) begin
      if (age_count != AGE_MAX) age_count = age_count + 1'b1;
    end else begin
      lv = audio_level(d[15:0]);
      rv = audio_level(d[31:16]);
      mv = mpx_level(d[55:32]);
      if (age_count > live_cfg.hold) begin
        // hold expired: every peak restarts from the current beat
        held_left = lv;
        held_right = rv;
        held_mpx = mv;
        age_count = '0;
      end else begin
        if (mv > held_mpx) begin
          held_mpx = mv;
          age_count = '0;
        end
        if (lv > held_left) begin
          held_left = lv;
          age_count = '0;
        end
        if (rv > held_right) begin
          held_right = rv;
          age_count = '0;
        end
      end
      rd.left_zone = grade_level(lv, live_cfg.audio_green, live_cfg.audio_yellow);
      rd.right_zone = grade_level(rv, live_cfg.audio_green, live_cfg.audio_yellow);
      rd.mpx_zone = grade_level(mv, live_cfg.mpx_green, live_cfg.mpx_yellow);
      rd.left_mark = (lv == held_left) && (held_left > live_cfg.audio_green);
      rd.right_mark = (rv == held_right) && (held_right > live_cfg.audio_green);
      spread = (mv >= held_mpx) ? mv - held_mpx : held_mpx - mv;
      rd.mpx_mark = (spread <= live_cfg.mpx_tol) && (mv > live_cfg.mpx_green);
    end
    rd.left_peak = held_left;
    rd.right_peak = held_right;
    rd.mpx_peak = held_mpx;
    return rd;
  endfunction

  task automatic flag_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("%0t: result %0d field %s: got 0x%0h, expected 0x%0h",
             $time, readings_seen, field, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    reading_t want;
    in_fire <= in_tvalid && in_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (!rst_n) begin
      live_cfg.audio_green = RST_AUDIO_GREEN;
      live_cfg.audio_yellow = RST_AUDIO_YELLOW;
      live_cfg.mpx_green = RST_MPX_GREEN;
      live_cfg.mpx_yellow = RST_MPX_YELLOW;
      live_cfg.mpx_tol = RST_MPX_TOL;
      live_cfg.hold = RST_HOLD_TICKS;
      held_left = '0;
      held_right = '0;
      held_mpx = '0;
      age_count = '0;
    end else begin
      // check the result first so a beat taken at this edge never matches itself
      if (out_tvalid && out_tready) begin
        if (reading_q.size() == 0) begin
          flag_mismatch("unexpected beat", out_tdata[63:0], 0);
        end else begin
          want = reading_q.pop_front();
          if (out_tdata[1:0] !== want.left_zone)
            flag_mismatch("left_zone", out_tdata[1:0], want.left_zone);
          if (out_tdata[3:2] !== want.right_zone)
            flag_mismatch("right_zone", out_tdata[3:2], want.right_zone);
          if (out_tdata[5:4] !== want.mpx_zone)
            flag_mismatch("mpx_zone", out_tdata[5:4], want.mpx_zone);
          if (out_tdata[21:6] !== want.left_peak)
            flag_mismatch("left_peak_out", out_tdata[21:6], want.left_peak);
          if (out_tdata[37:22] !== want.right_peak)
            flag_mismatch("right_peak_out", out_tdata[37:22], want.right_peak);
          if (out_tdata[61:38] !== want.mpx_peak)
            flag_mismatch("mpx_peak_out", out_tdata[61:38], want.mpx_peak);
          if (out_tdata[62] !== want.left_mark)
            flag_mismatch("left_mark", out_tdata[62], want.left_mark);
          if (out_tdata[63] !== want.right_mark)
            flag_mismatch("right_mark", out_tdata[63], want.right_mark);
          if (out_tdata[64] !== want.mpx_mark)
            flag_mismatch("mpx_mark", out_tdata[64], want.mpx_mark);
          if (out_tdata[OUT_TDATA_W-1:65] !== '0)
            flag_mismatch("padding", out_tdata[OUT_TDATA_W-1:65], 0);
        end
        readings_seen++;
      end
      if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
      if (in_tvalid && in_tready) reading_q.push_back(predict_reading(in_tuser, in_tdata));
    end
  end

  // ---------------------------------------------------------------- drivers

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire || cfg_fire) begin
        void'(feed_q.pop_front());
        presenting = 1'b0;
      end
      if (!presenting) begin
        if (feed_q.size() != 0 && feed_q[0].kind == BEAT_CALM) begin
          calm = 1'b1;
          void'(feed_q.pop_front());
        end
        if (feed_q.size() != 0 && feed_q[0].kind == BEAT_GAP) begin
          gap_left = feed_q[0].gap_len;
          void'(feed_q.pop_front());
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (feed_q.size() != 0) begin
          case (feed_q[0].kind)
            BEAT_ITEM: begin
              in_tdata <= {feed_q[0].mpx_s, feed_q[0].right_s, feed_q[0].left_s};
              in_tuser <= feed_q[0].mode;
              presenting = 1'b1;
            end
            BEAT_CFG: begin
              // registers change only once every result has drained
              if (reading_q.size() == 0) begin
                cfg_index <= feed_q[0].reg_idx;
                cfg_data <= feed_q[0].reg_val;
                presenting = 1'b1;
              end
            end
            BEAT_DRAIN: begin
              if (reading_q.size() == 0) void'(feed_q.pop_front());
            end
            default: ;
          endcase
        end
      end
      in_tvalid <= presenting && feed_q[0].kind == BEAT_ITEM;
      cfg_valid <= presenting && feed_q[0].kind == BEAT_CFG;
    end
  end

  always @(negedge clk) begin
    if (cycle_count % 150 == 0) out_bursty = ($urandom_range(0, 2) != 0);
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rst_n && !calm && out_bursty && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void push_beat(feed_kind_t k, logic mode, logic [AUDIO_W-1:0] l,
                                    logic [AUDIO_W-1:0] r, logic [MPX_W-1:0] m,
                                    logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val,
                                    int len);
    feed_q.push_back('{kind: k, mode: mode, left_s: l, right_s: r, mpx_s: m,
                       reg_idx: idx, reg_val: val, gap_len: len});
  endfunction

  function automatic void add_item(logic mode, logic [AUDIO_W-1:0] l,
                                   logic [AUDIO_W-1:0] r, logic [MPX_W-1:0] m);
    push_beat(BEAT_ITEM, mode, l, r, m, '0, '0, 0);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    push_beat(BEAT_CFG, MODE_SAMPLE, '0, '0, '0, idx, val, 0);
  endfunction

  function automatic void add_settings(meter_cfg_t s, bit junk);
    logic [7:0] hi;
    hi = junk ? 8'($urandom) : 8'd0;
    add_cfg(REG_AUDIO_GREEN, {hi, s.audio_green});
    add_cfg(REG_AUDIO_YELLOW, {~hi, s.audio_yellow});
    add_cfg(REG_MPX_GREEN, s.mpx_green);
    add_cfg(REG_MPX_YELLOW, s.mpx_yellow);
    add_cfg(REG_MPX_TOL, s.mpx_tol);
    add_cfg(REG_HOLD_TICKS, {hi, s.hold});
    gen_cfg = s;
  endfunction

  function automatic meter_cfg_t rand_settings();
    meter_cfg_t s;
    s.audio_green = AUDIO_W'($urandom_range(0, AUDIO_FULL));
    s.audio_yellow = AUDIO_W'($urandom_range(s.audio_green, AUDIO_FULL));
    s.mpx_green = MPX_W'($urandom_range(0, MPX_FULL));
    s.mpx_yellow = MPX_W'($urandom_range(s.mpx_green, MPX_FULL));
    s.mpx_tol = $urandom_range(0, 1) ? MPX_W'($urandom_range(0, 8000))
                                     : MPX_W'($urandom_range(0, MPX_FULL));
    s.hold = ($urandom_range(0, 3) != 0) ? AGE_W'($urandom_range(0, 6))
                                         : AGE_W'($urandom_range(7, 600));
    return s;
  endfunction

  // magnitudes cluster around thresholds and recent values so marks and zone edges hit
  function automatic logic [AUDIO_W-1:0] pick_audio();
    int mag;
    case ($urandom_range(0, 6))
      0: return AUDIO_W'($urandom);
      1: mag = int'(gen_cfg.audio_green) + int'($urandom_range(0, 2)) - 1;
      2: mag = int'(gen_cfg.audio_yellow) + int'($urandom_range(0, 2)) - 1;
      3: mag = recent_audio;
      4: mag = $urandom_range(0, 300);
      5: mag = $urandom_range(0, AUDIO_FULL);
      default: mag = $urandom_range(0, 1) ? AUDIO_FULL : AUDIO_FULL - 1;
    endcase
    if (mag < 0) mag = 0;
    if (mag > AUDIO_FULL) mag = AUDIO_FULL;
    recent_audio = mag;
    return $urandom_range(0, 1) ? AUDIO_W'(-mag) : AUDIO_W'(mag);
  endfunction

  function automatic logic [MPX_W-1:0] pick_mpx();
    int mag;
    int tol;
    tol = gen_cfg.mpx_tol;
    case ($urandom_range(0, 7))
      0: return MPX_W'($urandom);
      1: mag = int'(gen_cfg.mpx_green) + int'($urandom_range(0, 2)) - 1;
      2: mag = int'(gen_cfg.mpx_yellow) + int'($urandom_range(0, 2)) - 1;
      3: mag = recent_mpx - int'($urandom_range(0, tol));
      4: mag = recent_mpx - tol - int'($urandom_range(0, 1));
      5: mag = $urandom_range(0, 4000);
      6: mag = $urandom_range(0, MPX_FULL);
      default: mag = $urandom_range(0, 1) ? MPX_FULL : MPX_FULL - 1;
    endcase
    if (mag < 0) mag = 0;
    if (mag > MPX_FULL) mag = MPX_FULL;
    if (mag > recent_mpx) recent_mpx = mag;
    else if ($urandom_range(0, 7) == 0) recent_mpx = mag;
    return $urandom_range(0, 1) ? MPX_W'(-mag) : MPX_W'(mag);
  endfunction

  function automatic void run_random(int n, bit bursts);
    bit noisy;
    noisy = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) noisy = bursts && ($urandom_range(0, 2) != 0);
      if (noisy && $urandom_range(0, 3) == 0)
        push_beat(BEAT_GAP, MODE_SAMPLE, '0, '0, '0, '0, '0, $urandom_range(1, 6));
      // the sender holds off until the block has nothing in flight
      if (bursts && k == n / 2)
        push_beat(BEAT_DRAIN, MODE_SAMPLE, '0, '0, '0, '0, '0, 0);
      if ($urandom_range(0, 9) < 3)
        add_item(MODE_TICK, AUDIO_W'($urandom), AUDIO_W'($urandom), MPX_W'($urandom));
      else
        add_item(MODE_SAMPLE, pick_audio(), pick_audio(), pick_mpx());
    end
  endfunction

  initial begin
    meter_cfg_t s;
    gen_cfg = {RST_AUDIO_GREEN, RST_AUDIO_YELLOW, RST_MPX_GREEN, RST_MPX_YELLOW,
               RST_MPX_TOL, RST_HOLD_TICKS};

    // directed beats on the reset thresholds
    add_item(MODE_SAMPLE, 16'd0, 16'd0, 24'd0);
    add_item(MODE_TICK, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    add_item(MODE_SAMPLE, 16'd8230, 16'(-8230), 24'd2097264);
    add_item(MODE_SAMPLE, 16'd8231, 16'(-8231), 24'd2097265);
    add_item(MODE_SAMPLE, 16'd11626, 16'd11627, 24'd2621580);
    add_item(MODE_SAMPLE, 16'(-11627), 16'(-11626), 24'(-2621581));
    // mpx marker just inside and just outside the tolerance below the peak
    add_item(MODE_SAMPLE, 16'd0, 16'd0, 24'd2618086);
    add_item(MODE_SAMPLE, 16'd0, 16'd0, 24'd2618085);
    add_item(MODE_TICK, 16'h8000, 16'h8000, 24'h800000);
    add_item(MODE_SAMPLE, 16'h7FFF, 16'h8000, 24'h7FFFFF);
    add_item(MODE_SAMPLE, 16'h8000, 16'h7FFF, 24'h800000);
    add_item(MODE_SAMPLE, 16'hFFFF, 16'h0001, 24'hFFFFFF);
    add_item(MODE_SAMPLE, 16'h8000, 16'h8000, 24'h800000);
    add_item(MODE_TICK, 16'd0, 16'd0, 24'd0);

    add_settings(rand_settings(), 1'b0);
    run_random(160, 1'b1);

    s = '0;
    add_settings(s, 1'b0);
    run_random(130, 1'b1);

    s = {16'd32768, 16'd32768, 24'd8388608, 24'd8388608, 24'd8388608, 16'd65535};
    add_settings(s, 1'b0);
    run_random(130, 1'b1);

    // thresholds out of order: yellow below green
    s = rand_settings();
    s.audio_green = AUDIO_W'($urandom_range(16000, AUDIO_FULL));
    s.audio_yellow = AUDIO_W'($urandom_range(0, 12000));
    s.mpx_green = MPX_W'($urandom_range(4000000, MPX_FULL));
    s.mpx_yellow = MPX_W'($urandom_range(0, 3000000));
    add_settings(s, 1'b0);
    run_random(150, 1'b1);

    // short hold: ticks past the hold time make the next sample set reload
    add_cfg(REG_HOLD_TICKS, 24'd2);
    gen_cfg.hold = 16'd2;
    add_item(MODE_SAMPLE, 16'h8000, 16'h8000, 24'h800000);
    for (int k = 0; k < 3; k++)
      add_item(MODE_TICK, AUDIO_W'($urandom), AUDIO_W'($urandom), MPX_W'($urandom));
    add_item(MODE_SAMPLE, 16'd5, 16'(-7), 24'd9);
    add_item(MODE_SAMPLE, 16'd3, 16'd3, 24'(-3));

    add_cfg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    add_cfg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    add_settings(rand_settings(), 1'b1);
    run_random(180, 1'b1);

    push_beat(BEAT_CALM, MODE_SAMPLE, '0, '0, '0, '0, '0, 0);
    add_settings(rand_settings(), 1'b0);
    run_random(180, 1'b0);

    while (feed_q.size() != 0 || presenting || reading_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
